/* hw/rtl/mwms_pkg.sv */
// mwms_pkg: shared constants for the least-weight multiple search block
// used by the channel interfaces and by min_weight_multiple_search_top
`default_nettype none

package mwms_pkg;

   // default modulus width; the search space is MODULUS_BITS x 2^MODULUS_BITS states
   localparam int MODULUS_BITS_DEFAULT = 12;

   // width of the min_weight result field
   localparam int RESULT_WIDTH = 4;

endpackage : mwms_pkg

`default_nettype wire

/* hw/rtl/mwms_if.sv */
// mwms_if: valid/ready channel interfaces for the least-weight multiple search
// depends on mwms_pkg for the default modulus width and the result width
`default_nettype none

interface mwms_req_if #(
   parameter int MODULUS_BITS = mwms_pkg::MODULUS_BITS_DEFAULT
);
   logic                    valid;
   logic                    ready;
   logic [MODULUS_BITS-1:0] modulus;

   modport source (output valid, output modulus, input ready);
   modport sink   (input valid, input modulus, output ready);
endinterface : mwms_req_if

interface mwms_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [mwms_pkg::RESULT_WIDTH-1:0] min_weight;
   logic                              is_sturdy_flag;

   modport source (output valid, output min_weight, output is_sturdy_flag, input ready);
   modport sink   (input valid, input min_weight, input is_sturdy_flag, output ready);
endinterface : mwms_rsp_if

`default_nettype wire

/* hw/rtl/min_weight_multiple_search_top.sv */
// min_weight_multiple_search_top: breadth-first search for the least one-bit
// weight of a positive multiple of a modulus; depends on mwms_pkg and mwms_if
//
// usage
//   req_chan carries one word: modulus n (MODULUS_BITS wide). rsp_chan returns one
//   word per request: min_weight (least one-bit count of a multiple of n, capped
//   at popcount(n)) and is_sturdy_flag (min_weight equals popcount(n)).
//   req_chan.ready is high only while the block is idle; one request is worked on
//   at a time.
// sequence
//   popcount(n) <= 2: the result is shown in the cycle after the request is taken.
//   otherwise: a clearing pass writes every entry of the visited bitmap,
//   MODULUS_BITS * 2^MODULUS_BITS entries (49152 at the default), then a seed step;
//   each dequeued state passes the pop, load, check-zero and check-one steps, and
//   a last pop step sees the queue empty; at most (popcount(n)-1) * n states are
//   reached. The steps per state are set by the one read port of the visited
//   bitmap and the one shared compare-subtract unit that forms 2r mod n and
//   2r+1 mod n.
// reset
//   synchronous reset returns the sequencer to idle and drops rsp_chan.valid.
// stall
//   the result is held in rsp_chan with valid high until the receiver takes it;
//   no new request is taken before then.
`default_nettype none

module min_weight_multiple_search_top #(
   parameter int MODULUS_BITS = mwms_pkg::MODULUS_BITS_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   mwms_req_if.sink    req_chan,
   mwms_rsp_if.source  rsp_chan
);

   localparam int RB    = MODULUS_BITS;
   localparam int WB    = $clog2(MODULUS_BITS);
   localparam int IB    = WB + RB;
   localparam int DEPTH = MODULUS_BITS << MODULUS_BITS;
   localparam int LB    = $clog2(MODULUS_BITS + 1);
   localparam int RW    = mwms_pkg::RESULT_WIDTH;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_CLEAR = 8'b0000_0010,
      ST_SEED  = 8'b0000_0100,
      ST_POP   = 8'b0000_1000,
      ST_LOAD  = 8'b0001_0000,
      ST_CHK0  = 8'b0010_0000,
      ST_CHK1  = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   function automatic logic [LB-1:0] pop_count(input logic [RB-1:0] v);
      logic [LB-1:0] c;
      c = '0;
      for (int i = 0; i < RB; i++) begin
         c = c + LB'(v[i]);
      end
      return c;
   endfunction

   state_type      state_ff, state_in;
   logic [RB-1:0]  held_ff, held_in;
   logic [LB-1:0]  limit_ff, limit_in;
   logic [LB-1:0]  best_ff, best_in;
   logic [IB-1:0]  clr_ff, clr_in;
   logic [IB-1:0]  head_ff, head_in;
   logic [IB-1:0]  tail_ff, tail_in;
   logic [WB-1:0]  cw_ff, cw_in;
   logic [RB-1:0]  nr0_ff, nr0_in;
   logic [RB-1:0]  nr1_ff, nr1_in;
   logic           ok_ff, ok_in;

   // visited bitmap and state queue
   logic           visited_mem [DEPTH];
   logic [IB-1:0]  queue_mem [DEPTH];
   logic           vis_rd_ff;
   logic [IB-1:0]  q_rd_ff;

   logic           vis_we;
   logic [IB-1:0]  vis_wa;
   logic           vis_wd;
   logic [IB-1:0]  vis_ra;
   logic           q_we;
   logic [IB-1:0]  q_wd;

   // shared compare-subtract unit: x mod n for x < 2n
   logic [RB:0]    mod_x;
   logic [RB-1:0]  mod_y;
   logic [RB:0]    mod_diff;

   logic [LB-1:0]  req_pop;
   logic [WB-1:0]  cw1;
   logic           req_take;
   logic           rsp_take;

   assign mod_diff = mod_x - {1'b0, held_ff};
   assign mod_y    = (mod_x >= {1'b0, held_ff}) ? mod_diff[RB-1:0] : mod_x[RB-1:0];

   assign req_pop  = pop_count(req_chan.modulus);
   assign cw1      = cw_ff + WB'(1);
   assign req_take = req_chan.valid && req_chan.ready;
   assign rsp_take = rsp_chan.valid && rsp_chan.ready;

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign rsp_chan.valid          = (state_ff == ST_DONE);
   assign rsp_chan.min_weight     = RW'(best_ff);
   assign rsp_chan.is_sturdy_flag = (best_ff == limit_ff);

   always_comb begin
      state_in = state_ff;
      held_in  = held_ff;
      limit_in = limit_ff;
      best_in  = best_ff;
      clr_in   = clr_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      cw_in    = cw_ff;
      nr0_in   = nr0_ff;
      nr1_in   = nr1_ff;
      ok_in    = ok_ff;
      vis_we   = 1'b0;
      vis_wa   = clr_ff;
      vis_wd   = 1'b0;
      vis_ra   = {cw_ff, nr1_ff};
      q_we     = 1'b0;
      q_wd     = {cw_ff, nr0_ff};
      mod_x    = {1'b0, nr0_ff} + (RB+1)'(1);

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               held_in  = req_chan.modulus;
               limit_in = req_pop;
               best_in  = req_pop;
               clr_in   = '0;
               // empty queue for the new word, the seed goes to entry 0
               head_in  = '0;
               tail_in  = '0;
               state_in = (req_pop <= LB'(2)) ? ST_DONE : ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            vis_we = 1'b1;
            vis_wa = clr_ff;
            vis_wd = 1'b0;
            clr_in = clr_ff + IB'(1);
            if (clr_ff == IB'(DEPTH - 1)) begin
               state_in = ST_SEED;
            end
         end
         ST_SEED: begin
            // start from the single leading one bit: weight 1, residue 1
            vis_we   = 1'b1;
            vis_wa   = {WB'(1), RB'(1)};
            vis_wd   = 1'b1;
            q_we     = 1'b1;
            q_wd     = {WB'(1), RB'(1)};
            head_in  = '0;
            tail_in  = IB'(1);
            state_in = ST_POP;
         end
         ST_POP: begin
            if (head_ff == tail_ff) begin
               state_in = ST_DONE;
            end else begin
               head_in  = head_ff + IB'(1);
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            mod_x    = {q_rd_ff[RB-1:0], 1'b0};
            cw_in    = q_rd_ff[IB-1:RB];
            nr0_in   = mod_y;
            vis_ra   = {q_rd_ff[IB-1:RB], mod_y};
            state_in = ST_CHK0;
         end
         ST_CHK0: begin
            // append a zero bit: (w, 2r mod n)
            if (!vis_rd_ff) begin
               vis_we  = 1'b1;
               vis_wa  = {cw_ff, nr0_ff};
               vis_wd  = 1'b1;
               q_we    = 1'b1;
               q_wd    = {cw_ff, nr0_ff};
               tail_in = tail_ff + IB'(1);
            end
            if (nr0_ff == '0 && LB'(cw_ff) < best_ff) begin
               best_in = LB'(cw_ff);
            end
            // append a one bit: (w+1, 2r+1 mod n), only below the weight limit
            mod_x    = {1'b0, nr0_ff} + (RB+1)'(1);
            nr1_in   = mod_y;
            ok_in    = (LB'(cw_ff) + LB'(1)) < limit_ff;
            vis_ra   = ((LB'(cw_ff) + LB'(1)) < limit_ff) ? {cw1, mod_y} : {cw_ff, mod_y};
            state_in = ST_CHK1;
         end
         ST_CHK1: begin
            if (ok_ff) begin
               if (!vis_rd_ff) begin
                  vis_we  = 1'b1;
                  vis_wa  = {cw1, nr1_ff};
                  vis_wd  = 1'b1;
                  q_we    = 1'b1;
                  q_wd    = {cw1, nr1_ff};
                  tail_in = tail_ff + IB'(1);
               end
               if (nr1_ff == '0 && LB'(cw1) < best_ff) begin
                  best_in = LB'(cw1);
               end
            end
            state_in = ST_POP;
         end
         ST_DONE: begin
            if (rsp_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         held_ff  <= '0;
         limit_ff <= '0;
         best_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         held_ff  <= held_in;
         limit_ff <= limit_in;
         best_ff  <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      clr_ff <= clr_in;
      cw_ff  <= cw_in;
      nr0_ff <= nr0_in;
      nr1_ff <= nr1_in;
      ok_ff  <= ok_in;
   end

   always_ff @(posedge clock) begin
      if (vis_we) begin
         visited_mem[vis_wa] <= vis_wd;
      end
      vis_rd_ff <= visited_mem[vis_ra];
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         queue_mem[tail_ff] <= q_wd;
      end
      q_rd_ff <= queue_mem[head_ff];
   end

   // the read pointer never passes the write pointer
   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("queue head passed tail");

   // a taken request starts either the clearing pass or a direct answer
   a_req_next: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_CLEAR || state_ff == ST_DONE))
      else $error("unexpected state after request");

   // the best weight found never exceeds the popcount limit
   a_best_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (best_ff <= limit_ff))
      else $error("best weight above limit");

endmodule : min_weight_multiple_search_top

`default_nettype wire

/* test/min_weight_multiple_search_top_tb.sv */
// min_weight_multiple_search_top_tb: self-checking bench for the least-weight multiple search
// depends on mwms_pkg, mwms_req_if / mwms_rsp_if and min_weight_multiple_search_top
// a directed table is followed by random moduli under four idle/stall mixes, checked in order
`timescale 1ns / 1ps

module min_weight_multiple_search_top_tb;

   localparam int MODULUS_BITS = mwms_pkg::MODULUS_BITS_DEFAULT;
   localparam int RESIDUE_COUNT = 1 << MODULUS_BITS;
   localparam int RANDOM_PER_PHASE = 19;
   localparam int MAX_REPORTS = 10;

   typedef logic [MODULUS_BITS-1:0] modulus_type;
   typedef logic [mwms_pkg::RESULT_WIDTH-1:0] weight_type;

   typedef struct packed {
      modulus_type modulus;
      bit          fixed;   // expected value typed in below
      weight_type  weight;
      bit          sturdy;
   } directed_row_type;

   typedef struct {
      modulus_type modulus;
      weight_type  weight;
      bit          sturdy;
   } weight_rec_type;

   localparam int DIRECTED_COUNT = 24;

   directed_row_type directed_rows [0:DIRECTED_COUNT-1] = '{
      '{12'd0,    1'b1, 4'd0, 1'b1},
      '{12'd1,    1'b1, 4'd1, 1'b1},
      '{12'd2,    1'b1, 4'd1, 1'b1},
      '{12'd3,    1'b1, 4'd2, 1'b1},
      '{12'd5,    1'b1, 4'd2, 1'b1},
      '{12'd2048, 1'b1, 4'd1, 1'b1},
      '{12'd2049, 1'b1, 4'd2, 1'b1},
      '{12'd3072, 1'b1, 4'd2, 1'b1},
      '{12'h041,  1'b1, 4'd2, 1'b1},
      '{12'd7,    1'b0, 4'd0, 1'b0},
      '{12'd11,   1'b0, 4'd0, 1'b0},
      '{12'd13,   1'b0, 4'd0, 1'b0},
      '{12'd21,   1'b0, 4'd0, 1'b0},
      '{12'd23,   1'b0, 4'd0, 1'b0},
      '{12'd37,   1'b0, 4'd0, 1'b0},
      '{12'd73,   1'b0, 4'd0, 1'b0},
      '{12'd127,  1'b0, 4'd0, 1'b0},
      '{12'd255,  1'b0, 4'd0, 1'b0},
      '{12'h555,  1'b0, 4'd0, 1'b0},
      '{12'hAAA,  1'b0, 4'd0, 1'b0},
      '{12'd1023, 1'b0, 4'd0, 1'b0},
      '{12'd4093, 1'b0, 4'd0, 1'b0},
      '{12'd2047, 1'b0, 4'd0, 1'b0},
      '{12'd4095, 1'b0, 4'd0, 1'b0}
   };

   logic clock;
   logic reset;

   mwms_req_if #(.MODULUS_BITS(MODULUS_BITS)) req_chan ();
   mwms_rsp_if rsp_chan ();

   min_weight_multiple_search_top #(
      .MODULUS_BITS(MODULUS_BITS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   weight_rec_type expected_weights [$];
   int             send_gap_pct;
   int             recv_stall_pct;
   int             mismatch_count;
   int             words_sent;
   int             words_checked;
   int             searched_count;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #500_000_000;
      $display("min_weight_multiple_search_top test failed");
      $finish;
   end

   // least weight of a multiple, by weight layers: each layer is the closure
   // of its seed residues under doubling, the next layer seeds from 2r+1
   function automatic void predict_min_weight(input modulus_type n, output weight_type weight,
                                              output bit sturdy);
      int unsigned nn;
      int unsigned ones;
      int unsigned best;
      int unsigned r;
      int unsigned w;
      bit          reached [0:RESIDUE_COUNT-1];
      int unsigned layer [$];
      int unsigned seeds [$];
      int unsigned pending [$];
      nn = 32'(n);
      ones = $countones(n);
      best = ones;
      if (ones > 2) begin
         seeds.push_back(1);
         for (w = 1; w < ones && best == ones; w++) begin
            foreach (reached[i]) reached[i] = 1'b0;
            layer.delete();
            pending = seeds;
            while (pending.size() != 0) begin
               r = pending.pop_front();
               if (!reached[r]) begin
                  reached[r] = 1'b1;
                  layer.push_back(r);
                  pending.push_back((2 * r) % nn);
               end
            end
            if (reached[0]) best = w;
            seeds.delete();
            foreach (layer[i]) seeds.push_back((2 * layer[i] + 1) % nn);
         end
      end
      weight = best[mwms_pkg::RESULT_WIDTH-1:0];
      sturdy = (best == ones);
   endfunction

   // mostly cheap moduli: the search time grows with n, the clearing pass is fixed
   function automatic modulus_type pick_modulus();
      int unsigned k;
      modulus_type n;
      k = $urandom_range(99);
      if (k < 30) begin
         n = modulus_type'(1) << $urandom_range(MODULUS_BITS - 1);
         if ($urandom_range(1)) n = n | (modulus_type'(1) << $urandom_range(MODULUS_BITS - 1));
      end else if (k < 88) begin
         n = modulus_type'($urandom_range(255, 5));
      end else if (k < 96) begin
         n = modulus_type'($urandom_range(RESIDUE_COUNT - 1, 256));
      end else begin
         n = modulus_type'($urandom);
      end
      return n;
   endfunction

   // drive one word from a falling edge, return at the falling edge after acceptance
   task automatic send_modulus(input modulus_type n, input bit fixed, input weight_type weight,
                               input bit sturdy);
      weight_rec_type rec;
      while ($urandom_range(99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.modulus <= n;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      rec.modulus = n;
      if (fixed) begin
         rec.weight = weight;
         rec.sturdy = sturdy;
      end else begin
         predict_min_weight(n, rec.weight, rec.sturdy);
      end
      expected_weights.push_back(rec);
      words_sent++;
      if ($countones(n) > 2) searched_count++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      while (expected_weights.size() != 0) @(posedge clock);
   endtask

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      weight_rec_type rec;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_weights.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result word: weight %0d sturdy %0b",
                        rsp_chan.min_weight, rsp_chan.is_sturdy_flag);
         end else begin
            rec = expected_weights.pop_front();
            words_checked++;
            if (rsp_chan.min_weight !== rec.weight || rsp_chan.is_sturdy_flag !== rec.sturdy) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("modulus %0d: expected weight %0d sturdy %0b, got weight %0d sturdy %0b",
                           rec.modulus, rec.weight, rec.sturdy,
                           rsp_chan.min_weight, rsp_chan.is_sturdy_flag);
            end
         end
      end
   end

   initial begin
      int phase;
      int i;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.modulus = '0;
      send_gap_pct = 0;
      recv_stall_pct = 0;
      mismatch_count = 0;
      words_sent = 0;
      words_checked = 0;
      searched_count = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (i = 0; i < DIRECTED_COUNT; i++)
         send_modulus(directed_rows[i].modulus, directed_rows[i].fixed,
                      directed_rows[i].weight, directed_rows[i].sturdy);

      for (phase = 0; phase < 4; phase++) begin
         // hold off the sender until the block has returned everything
         req_chan.valid <= 1'b0;
         drain_results();
         @(negedge clock);
         case (phase)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 64; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 64; end
            default: begin send_gap_pct = 11; recv_stall_pct = 11; end
         endcase
         for (i = 0; i < RANDOM_PER_PHASE; i++)
            send_modulus(pick_modulus(), 1'b0, '0, 1'b0);
      end

      req_chan.valid <= 1'b0;
      drain_results();
      repeat (100) @(posedge clock);

      $display("sent %0d moduli (%0d needing a search), checked %0d result words",
               words_sent, searched_count, words_checked);
      $display("idle mixes: none, sender gaps, receiver stalls, both; %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("min_weight_multiple_search_top test passed");
      end else begin
         $display("min_weight_multiple_search_top test failed");
      end
      $finish;
   end

endmodule : min_weight_multiple_search_top_tb

/* filelist.f */
hw/rtl/mwms_pkg.sv
hw/rtl/mwms_if.sv
hw/rtl/min_weight_multiple_search_top.sv
test/min_weight_multiple_search_top_tb.sv
